[design/cpse_pkg.sv]
// ----------------------------------------------------------------------------
// cpse_pkg
// Types and constants shared by the CRC-32 path skip engine.
// ----------------------------------------------------------------------------
package cpse_pkg;

	localparam int CRC_W      = 32;
	localparam int BYTE_W     = 8;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	localparam logic [CRC_W-1:0]  CRC_POLY       = 32'h04C1_1DB7;
	localparam logic [BYTE_W-1:0] SLASH_CODE     = 8'h2F;
	localparam logic [BYTE_W-1:0] BACKSLASH_CODE = 8'h5C;

	typedef enum logic {
		REG_INIT_CRC        = 1'b0,
		REG_SKIP_SEPARATORS = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [CRC_W-1:0] init_crc;
		logic             skip_separators;
	} cpse_cfg_t;

endpackage

[design/cpse_channels.sv]
// ----------------------------------------------------------------------------
// cpse_channels
// Valid/ready channels: message bytes in, checksums out.
// ----------------------------------------------------------------------------
interface cpse_msg_if import cpse_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              first_byte;
	logic              last_byte;

	modport source (output valid, output data_byte, output first_byte, output last_byte,
		input ready);
	modport sink (input valid, input data_byte, input first_byte, input last_byte,
		output ready);
endinterface

interface cpse_sum_if import cpse_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CRC_W-1:0] checksum;

	modport source (output valid, output checksum, input ready);
	modport sink (input valid, input checksum, output ready);
endinterface

[design/cpse_regs.sv]
// ----------------------------------------------------------------------------
// cpse_regs
// APB configuration registers: start value and separator skip enable.
// ----------------------------------------------------------------------------
module cpse_regs import cpse_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cpse_cfg_t             cfg
);

	cpse_cfg_t cfg_q;
	cfg_reg_t  reg_sel;
	logic      wr_en;

	assign pready  = 1'b1;
	assign reg_sel = cfg_reg_t'(paddr[2]);
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_sel)
				REG_INIT_CRC:        cfg_q.init_crc        <= pwdata[CRC_W-1:0];
				REG_SKIP_SEPARATORS: cfg_q.skip_separators <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_INIT_CRC:        prdata = cfg_q.init_crc;
			REG_SKIP_SEPARATORS: prdata = {{(APB_DATA_W-1){1'b0}}, cfg_q.skip_separators};
			default:             prdata = '0;
		endcase
	end

endmodule

[design/cpse_crc_byte.sv]
// ----------------------------------------------------------------------------
// cpse_crc_byte
// One-byte CRC-32 update, LSB of the byte first, unrolled XOR network.
// ----------------------------------------------------------------------------
module cpse_crc_byte import cpse_pkg::*; (
	input  logic [CRC_W-1:0]  crc_in,
	input  logic [BYTE_W-1:0] data,
	output logic [CRC_W-1:0]  crc_out
);

	always_comb begin
		logic [CRC_W-1:0] r;
		logic             fb;
		r  = crc_in;
		fb = 1'b0;
		for (int k = 0; k < BYTE_W; k++) begin
			fb = r[CRC_W-1] ^ data[k];
			r  = {r[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
		end
		crc_out = r;
	end

endmodule

[design/crc32_path_skip_engine.sv]
// ----------------------------------------------------------------------------
// crc32_path_skip_engine
// CRC-32 (poly 04C11DB7, no final XOR) over a byte stream, with optional
// skipping of slash and backslash bytes.
// ----------------------------------------------------------------------------
// Accepts one message byte per cycle. A byte is registered on acceptance,
// folded into the CRC register by a combinational byte-wide XOR network
// when it advances, and on the last byte of a message the checksum is loaded
// into the output register, from which it is offered. The input stalls only
// while a checksum waits in the output register and the registered byte is
// itself a last byte. Configuration (start value at address 0, skip enable
// at address 4) should be written while no message is in flight.
// ----------------------------------------------------------------------------
module crc32_path_skip_engine import cpse_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	cpse_msg_if.sink              msg,
	cpse_sum_if.source            sum,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	cpse_cfg_t         cfg;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              first_s1;
	logic              last_s1;
	logic [CRC_W-1:0]  crc_q;
	logic [CRC_W-1:0]  base_crc;
	logic [CRC_W-1:0]  hashed_crc;
	logic [CRC_W-1:0]  crc_next;
	logic              out_valid_q;
	logic [CRC_W-1:0]  checksum_q;
	logic              is_sep;
	logic              out_free;
	logic              adv_s1;

	cpse_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign out_free  = !out_valid_q || sum.ready;
	assign adv_s1    = valid_s1 && (!last_s1 || out_free);
	assign msg.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (msg.ready) begin
			valid_s1 <= msg.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (msg.ready && msg.valid) begin
			byte_s1  <= msg.data_byte;
			first_s1 <= msg.first_byte;
			last_s1  <= msg.last_byte;
		end
	end

	assign base_crc = first_s1 ? cfg.init_crc : crc_q;
	assign is_sep   = (byte_s1 == SLASH_CODE) || (byte_s1 == BACKSLASH_CODE);

	cpse_crc_byte u_crc_byte (
		.crc_in  (base_crc),
		.data    (byte_s1),
		.crc_out (hashed_crc)
	);

	assign crc_next = (cfg.skip_separators && is_sep) ? base_crc : hashed_crc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
		end else if (adv_s1) begin
			crc_q <= crc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (sum.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			checksum_q <= crc_next;
		end
	end

	assign sum.valid    = out_valid_q;
	assign sum.checksum = checksum_q;

	a_last_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> (out_valid_q && checksum_q == $past(crc_next)))
		else $error("last item did not load checksum");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !sum.ready) |-> !(adv_s1 && last_s1))
		else $error("pending checksum overwritten");

	a_mid_item_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && !last_s1) |=> (out_valid_q == $past(out_valid_q && !sum.ready)))
		else $error("result raised by non-last item");

	a_crc_holds_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(crc_q))
		else $error("crc register changed without an item");

endmodule
